### rtl/fdp_pkg.sv
// ----------------------------------------------------------------------------
// fdp_pkg: shared types and constants of the feed distance profile.
// Segment codes, register indexes and the Bernstein control polygons.
// ----------------------------------------------------------------------------
package fdp_pkg;

	// Segment of the feed profile that a sample falls into.
	typedef enum logic [1:0] {
		SEG_ACCEL  = 2'd0,
		SEG_CRUISE = 2'd1,
		SEG_DECEL  = 2'd2
	} seg_t;

	// Configuration register indexes.
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_SPEED_START  = 3'd0,
		REG_SPEED_CRUISE = 3'd1,
		REG_SPEED_END    = 3'd2,
		REG_TIME_ACCEL   = 3'd3,
		REG_TIME_CRUISE  = 3'd4,
		REG_TIME_DECEL   = 3'd5,
		REG_DIST_ACCEL   = 3'd6,
		REG_DIST_CRUISE  = 3'd7
	} reg_idx_t;

	// Weights are Q2.30 and fit in 32 bits.
	localparam int WEIGHT_FRAC = 30;
	localparam int WEIGHT_W    = 32;

	// Distances and speeds are Q16.16.
	localparam int VALUE_FRAC = 16;

	// Output distance field width.
	localparam int DIST_W = 32;

	// Bits of the divide-by-six quotient resolved per stage.
	localparam int DIV_BITS = 8;

	// Control polygons of the two weight curves, in units of 2^WEIGHT_FRAC.
	localparam logic [1:0] CTL_A [0:6] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3};
	localparam logic [1:0] CTL_B [0:6] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3};

endpackage

### rtl/fdp_front.sv
// ----------------------------------------------------------------------------
// fdp_front: elapsed time and segment selection.
// Clamps tau, forms tau times the total time, picks the segment and subtracts its start.
// ----------------------------------------------------------------------------
module fdp_front #(
	parameter int TAU_FRAC_BITS = 16,
	parameter int VALUE_WIDTH   = 32,
	localparam int EL_W         = TAU_FRAC_BITS + VALUE_WIDTH + 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [TAU_FRAC_BITS:0]   tau,
	input  logic [VALUE_WIDTH-1:0]   time_accel,
	input  logic [VALUE_WIDTH-1:0]   time_cruise,
	input  logic [VALUE_WIDTH-1:0]   time_decel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output fdp_pkg::seg_t            out_seg,
	output logic [EL_W-1:0]          out_num,
	output logic                     out_zero
);
	import fdp_pkg::*;

	localparam int NS    = 3;
	localparam int TOT_W = VALUE_WIDTH + 2;
	localparam logic [TAU_FRAC_BITS:0] TAU_ONE = {1'b1, {TAU_FRAC_BITS{1'b0}}};

	logic [NS:1]   v_q;
	logic [NS:0]   vin;
	logic [NS+1:1] rdy;

	logic [TAU_FRAC_BITS:0] tau_s1;
	logic [TOT_W-1:0]       total_s1;
	logic [EL_W-1:0]        el_s2;
	logic                   zero_s2;
	seg_t                   seg_s3;
	logic [EL_W-1:0]        num_s3;
	logic                   zero_s3;

	logic [TOT_W+TAU_FRAC_BITS:0] prod_c;
	logic [VALUE_WIDTH:0]         sum_ac;
	logic [EL_W-1:0]              bnd_a;
	logic [EL_W-1:0]              bnd_b;

	// Stage valid bits and the ready chain.
	assign vin = {v_q, in_valid};
	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (rdy[k]) begin
					v_q[k] <= vin[k-1];
				end
			end
		end
	end

	// Stage 1: clamp tau and sum the segment times.
	always_ff @(posedge clk) begin
		if (rdy[1] && vin[0]) begin
			tau_s1   <= (tau > TAU_ONE) ? TAU_ONE : tau;
			total_s1 <= TOT_W'(time_accel) + TOT_W'(time_cruise) + TOT_W'(time_decel);
		end
	end

	// Stage 2: elapsed time in Q.TAU_FRAC_BITS of the time unit.
	assign prod_c = tau_s1 * total_s1;
	always_ff @(posedge clk) begin
		if (rdy[2] && vin[1]) begin
			el_s2   <= prod_c[EL_W-1:0];
			zero_s2 <= (total_s1 == '0);
		end
	end

	// Stage 3: compare with the segment boundaries and subtract the start.
	assign sum_ac = time_accel + time_cruise;
	assign bnd_a  = EL_W'(time_accel) << TAU_FRAC_BITS;
	assign bnd_b  = EL_W'(sum_ac) << TAU_FRAC_BITS;
	always_ff @(posedge clk) begin
		if (rdy[3] && vin[2]) begin
			zero_s3 <= zero_s2;
			priority if (el_s2 < bnd_a) begin
				seg_s3 <= SEG_ACCEL;
				num_s3 <= el_s2;
			end else if (el_s2 < bnd_b) begin
				seg_s3 <= SEG_CRUISE;
				num_s3 <= el_s2 - bnd_a;
			end else begin
				seg_s3 <= SEG_DECEL;
				num_s3 <= el_s2 - bnd_b;
			end
		end
	end

	assign out_valid = v_q[NS];
	assign out_seg   = seg_s3;
	assign out_num   = num_s3;
	assign out_zero  = zero_s3;

endmodule

### rtl/fdp_tdiv.sv
// ----------------------------------------------------------------------------
// fdp_tdiv: local time within the segment.
// Restoring division of the time into the segment by its length, one
// quotient bit per stage, with the end of the segment taken as exactly one.
// ----------------------------------------------------------------------------
module fdp_tdiv #(
	parameter int TAU_FRAC_BITS = 16,
	parameter int VALUE_WIDTH   = 32,
	localparam int EL_W         = TAU_FRAC_BITS + VALUE_WIDTH + 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  fdp_pkg::seg_t            in_seg,
	input  logic [EL_W-1:0]          in_num,
	input  logic                     in_zero,
	input  logic [VALUE_WIDTH-1:0]   time_accel,
	input  logic [VALUE_WIDTH-1:0]   time_cruise,
	input  logic [VALUE_WIDTH-1:0]   time_decel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output fdp_pkg::seg_t            out_seg,
	output logic [TAU_FRAC_BITS:0]   out_t,
	output logic                     out_zero
);
	import fdp_pkg::*;

	localparam int NS = TAU_FRAC_BITS + 1;
	localparam logic [TAU_FRAC_BITS:0] TAU_ONE = {1'b1, {TAU_FRAC_BITS{1'b0}}};

	logic [NS:1]   v_q;
	logic [NS:0]   vin;
	logic [NS+1:1] rdy;

	logic [EL_W-1:0]          num_s  [1:NS];
	logic [VALUE_WIDTH-1:0]   len_s  [1:NS];
	logic [TAU_FRAC_BITS-1:0] t_s    [1:NS];
	logic                     full_s [1:NS];
	seg_t                     seg_s  [1:NS];
	logic                     zero_s [1:NS];

	logic [VALUE_WIDTH-1:0] len_c;

	// Stage valid bits and the ready chain.
	assign vin = {v_q, in_valid};
	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (rdy[k]) begin
					v_q[k] <= vin[k-1];
				end
			end
		end
	end

	// Stage 1: segment length and the test for the end of the segment.
	always_comb begin
		unique case (in_seg)
			SEG_ACCEL:  len_c = time_accel;
			SEG_CRUISE: len_c = time_cruise;
			SEG_DECEL:  len_c = time_decel;
			default:    len_c = time_decel;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[1] && vin[0]) begin
			num_s[1]  <= in_num;
			len_s[1]  <= len_c;
			t_s[1]    <= '0;
			full_s[1] <= (len_c == '0) || (in_num >= (EL_W'(len_c) << TAU_FRAC_BITS));
			seg_s[1]  <= in_seg;
			zero_s[1] <= in_zero;
		end
	end

	// Later stages: one quotient bit each, most significant first.
	for (genvar k = 2; k <= NS; k++) begin : g_bit
		logic [EL_W-1:0] dsr;
		assign dsr = EL_W'(len_s[k-1]) << (NS - k);

		always_ff @(posedge clk) begin
			if (rdy[k] && vin[k-1]) begin
				len_s[k]  <= len_s[k-1];
				full_s[k] <= full_s[k-1];
				seg_s[k]  <= seg_s[k-1];
				zero_s[k] <= zero_s[k-1];
				if (num_s[k-1] >= dsr) begin
					num_s[k] <= num_s[k-1] - dsr;
					t_s[k]   <= t_s[k-1] | (TAU_FRAC_BITS'(1) << (NS - k));
				end else begin
					num_s[k] <= num_s[k-1];
					t_s[k]   <= t_s[k-1];
				end
			end
		end
	end

	assign out_valid = v_q[NS];
	assign out_seg   = seg_s[NS];
	assign out_zero  = zero_s[NS];
	assign out_t     = full_s[NS] ? TAU_ONE : {1'b0, t_s[NS]};

endmodule

### rtl/fdp_bern.sv
// ----------------------------------------------------------------------------
// fdp_bern: Bernstein weights of the degree six distance curve.
// De Casteljau evaluation of both weight curves, one level per stage.
// ----------------------------------------------------------------------------
module fdp_bern #(
	parameter int TAU_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fdp_pkg::seg_t                  in_seg,
	input  logic [TAU_FRAC_BITS:0]         in_t,
	input  logic                           in_zero,
	output logic                           out_valid,
	input  logic                           out_ready,
	output fdp_pkg::seg_t                  out_seg,
	output logic [fdp_pkg::WEIGHT_W-1:0]   out_wa,
	output logic [fdp_pkg::WEIGHT_W-1:0]   out_wb,
	output logic                           out_zero
);
	import fdp_pkg::*;

	localparam int NS    = 6;
	localparam int RND_W = WEIGHT_W + TAU_FRAC_BITS + 1;
	localparam logic [RND_W-1:0] HALF = RND_W'(1) << (TAU_FRAC_BITS - 1);

	// One interpolation step with round half up.
	function automatic logic [WEIGHT_W-1:0] lerp(input logic [WEIGHT_W-1:0] lo,
		input logic [WEIGHT_W-1:0] hi, input logic [TAU_FRAC_BITS:0] t);
		logic [WEIGHT_W-1:0] diff;
		logic [RND_W-1:0]    prod;
		logic [RND_W-1:0]    rnd;
		diff = hi - lo;
		prod = diff * t;
		rnd  = prod + HALF;
		return lo + rnd[TAU_FRAC_BITS+WEIGHT_W-1:TAU_FRAC_BITS];
	endfunction

	function automatic logic [WEIGHT_W-1:0] ctl_pt(input logic [1:0] c);
		return WEIGHT_W'(c) << WEIGHT_FRAC;
	endfunction

	logic [NS:1]   v_q;
	logic [NS:0]   vin;
	logic [NS+1:1] rdy;

	logic [WEIGHT_W-1:0]    pa_s   [1:NS][0:5];
	logic [WEIGHT_W-1:0]    pb_s   [1:NS][0:5];
	logic [TAU_FRAC_BITS:0] t_s    [1:NS];
	seg_t                   seg_s  [1:NS];
	logic                   zero_s [1:NS];

	// Stage valid bits and the ready chain.
	assign vin = {v_q, in_valid};
	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (rdy[k]) begin
					v_q[k] <= vin[k-1];
				end
			end
		end
	end

	// Each level has one point fewer than the level before it.
	for (genvar L = 1; L <= NS; L++) begin : g_lvl
		if (L == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (rdy[1] && vin[0]) begin
					for (int i = 0; i < 6; i++) begin
						pa_s[1][i] <= lerp(ctl_pt(CTL_A[i]), ctl_pt(CTL_A[i+1]), in_t);
						pb_s[1][i] <= lerp(ctl_pt(CTL_B[i]), ctl_pt(CTL_B[i+1]), in_t);
					end
					t_s[1]    <= in_t;
					seg_s[1]  <= in_seg;
					zero_s[1] <= in_zero;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (rdy[L] && vin[L-1]) begin
					for (int i = 0; i < 7 - L; i++) begin
						pa_s[L][i] <= lerp(pa_s[L-1][i], pa_s[L-1][i+1], t_s[L-1]);
						pb_s[L][i] <= lerp(pb_s[L-1][i], pb_s[L-1][i+1], t_s[L-1]);
					end
					t_s[L]    <= t_s[L-1];
					seg_s[L]  <= seg_s[L-1];
					zero_s[L] <= zero_s[L-1];
				end
			end
		end
	end

	assign out_valid = v_q[NS];
	assign out_seg   = seg_s[NS];
	assign out_zero  = zero_s[NS];
	assign out_wa    = pa_s[NS][0];
	assign out_wb    = pb_s[NS][0];

endmodule

### rtl/fdp_scale.sv
// ----------------------------------------------------------------------------
// fdp_scale: speed blend, segment scaling and offset.
// Weighs the speeds, scales by segment time over six with a pipelined
// divide by six, adds the earlier segments' distance and saturates.
// ----------------------------------------------------------------------------
module fdp_scale #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fdp_pkg::seg_t                  in_seg,
	input  logic [fdp_pkg::WEIGHT_W-1:0]   in_wa,
	input  logic [fdp_pkg::WEIGHT_W-1:0]   in_wb,
	input  logic                           in_zero,
	input  logic [VALUE_WIDTH-1:0]         speed_start,
	input  logic [VALUE_WIDTH-1:0]         speed_cruise,
	input  logic [VALUE_WIDTH-1:0]         speed_end,
	input  logic [VALUE_WIDTH-1:0]         time_accel,
	input  logic [VALUE_WIDTH-1:0]         time_cruise,
	input  logic [VALUE_WIDTH-1:0]         time_decel,
	input  logic [VALUE_WIDTH-1:0]         dist_accel,
	input  logic [VALUE_WIDTH-1:0]         dist_cruise,
	output logic                           out_valid,
	input  logic                           out_ready,
	output fdp_pkg::seg_t                  out_seg,
	output logic [VALUE_WIDTH-1:0]         out_dist
);
	import fdp_pkg::*;

	localparam int VW     = VALUE_WIDTH;
	localparam int MUL_W  = VW + WEIGHT_W;
	localparam int SPD_W  = VW + 3;
	localparam int PROD_W = 2 * VW + 4;
	localparam int DQ_W   = PROD_W - VALUE_FRAC;
	localparam int NDS    = (VW + DIV_BITS - 1) / DIV_BITS;
	localparam int KD     = 5;
	localparam int NS     = KD + NDS;
	localparam logic [VW-1:0]     VMAX    = {VW{1'b1}};
	localparam logic [MUL_W:0]    ACC_RND = (MUL_W+1)'(1) << (WEIGHT_FRAC - 1);
	localparam logic [PROD_W-1:0] LEN_RND = PROD_W'(3) << VALUE_FRAC;
	localparam logic [DQ_W-1:0]   SAT_LIM = DQ_W'(6) << VW;
	localparam logic [3:0]        SIX     = 4'd6;

	logic [NS:1]   v_q;
	logic [NS:0]   vin;
	logic [NS+1:1] rdy;

	// Fixed stages.
	logic [MUL_W-1:0] ma_s1, mb_s1;
	seg_t             seg_s1, seg_s2, seg_s3, seg_s4;
	logic             zero_s1, zero_s2, zero_s3, zero_s4;
	logic [SPD_W-1:0] spd_s2;
	logic [2*VW-1:0]  plo_s3;
	logic [SPD_W-1:0] phi_s3;
	logic [SPD_W-1:0] dq_s4;
	logic [2:0]       rem_s4;
	logic             sat_s4;

	// Divide-by-six stages.
	logic [SPD_W-1:0] dv_dq_s   [0:NDS-1];
	logic [2:0]       dv_rem_s  [0:NDS-1];
	logic [VW-1:0]    dv_quo_s  [0:NDS-1];
	logic             dv_sat_s  [0:NDS-1];
	seg_t             dv_seg_s  [0:NDS-1];
	logic             dv_zero_s [0:NDS-1];

	// Final stage.
	logic [VW-1:0] dist_sf;
	seg_t          seg_sf;

	logic [VW-1:0]     v1_c, v2_c, len_c, base_c, segd_c;
	logic [MUL_W-1:0]  ma_c, mb_c;
	logic [MUL_W:0]    acc_c;
	logic [2*VW-1:0]   plo_c;
	logic [SPD_W-1:0]  phi_c;
	logic [PROD_W-1:0] prod_c;
	logic [DQ_W-1:0]   dq_c;
	logic [VW:0]       dsum_c, tot_c;

	// Stage valid bits and the ready chain.
	assign vin = {v_q, in_valid};
	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (rdy[k]) begin
					v_q[k] <= vin[k-1];
				end
			end
		end
	end

	// Stage 1: weigh the two segment speeds.
	always_comb begin
		unique case (in_seg)
			SEG_ACCEL: begin
				v1_c = speed_start;
				v2_c = speed_cruise;
			end
			SEG_CRUISE: begin
				v1_c = speed_cruise;
				v2_c = speed_cruise;
			end
			default: begin
				v1_c = speed_cruise;
				v2_c = speed_end;
			end
		endcase
	end
	assign ma_c = v1_c * in_wa;
	assign mb_c = v2_c * in_wb;

	always_ff @(posedge clk) begin
		if (rdy[1] && vin[0]) begin
			ma_s1   <= ma_c;
			mb_s1   <= mb_c;
			seg_s1  <= in_seg;
			zero_s1 <= in_zero;
		end
	end

	// Stage 2: sum and round the blended speed back to Q16.16.
	assign acc_c = ma_s1 + mb_s1 + ACC_RND;
	always_ff @(posedge clk) begin
		if (rdy[2] && vin[1]) begin
			spd_s2  <= acc_c[MUL_W:WEIGHT_FRAC];
			seg_s2  <= seg_s1;
			zero_s2 <= zero_s1;
		end
	end

	// Stage 3: segment length times speed, as two partial products.
	always_comb begin
		unique case (seg_s2)
			SEG_ACCEL:  len_c = time_accel;
			SEG_CRUISE: len_c = time_cruise;
			default:    len_c = time_decel;
		endcase
	end
	assign plo_c = len_c * spd_s2[VW-1:0];
	assign phi_c = len_c * spd_s2[SPD_W-1:VW];

	always_ff @(posedge clk) begin
		if (rdy[3] && vin[2]) begin
			plo_s3  <= plo_c;
			phi_s3  <= phi_c;
			seg_s3  <= seg_s2;
			zero_s3 <= zero_s2;
		end
	end

	// Stage 4: combine, round, drop the fraction and test for overflow.
	assign prod_c = PROD_W'(plo_s3) + (PROD_W'(phi_s3) << VW) + LEN_RND;
	assign dq_c   = prod_c[PROD_W-1:VALUE_FRAC];

	always_ff @(posedge clk) begin
		if (rdy[4] && vin[3]) begin
			dq_s4   <= dq_c[SPD_W-1:0];
			rem_s4  <= dq_c[SPD_W-1:VW];
			sat_s4  <= (dq_c >= SAT_LIM);
			seg_s4  <= seg_s3;
			zero_s4 <= zero_s3;
		end
	end

	// Divide by six, several quotient bits per stage, most significant first.
	for (genvar d = 0; d < NDS; d++) begin : g_div
		logic [SPD_W-1:0] dq_in;
		logic [2:0]       rem_in;
		logic [VW-1:0]    quo_in;
		logic             sat_in;
		seg_t             seg_in;
		logic             zero_in;
		logic [2:0]       rem_c;
		logic [VW-1:0]    quo_c;

		if (d == 0) begin : g_src0
			assign dq_in   = dq_s4;
			assign rem_in  = rem_s4;
			assign quo_in  = '0;
			assign sat_in  = sat_s4;
			assign seg_in  = seg_s4;
			assign zero_in = zero_s4;
		end else begin : g_srcn
			assign dq_in   = dv_dq_s[d-1];
			assign rem_in  = dv_rem_s[d-1];
			assign quo_in  = dv_quo_s[d-1];
			assign sat_in  = dv_sat_s[d-1];
			assign seg_in  = dv_seg_s[d-1];
			assign zero_in = dv_zero_s[d-1];
		end

		always_comb begin
			logic [3:0] r4;
			int         b;
			rem_c = rem_in;
			quo_c = quo_in;
			r4    = '0;
			for (int j = 0; j < DIV_BITS; j++) begin
				b = VW - 1 - (d * DIV_BITS + j);
				if (b >= 0) begin
					r4 = {rem_c, dq_in[b]};
					if (r4 >= SIX) begin
						rem_c    = 3'(r4 - SIX);
						quo_c[b] = 1'b1;
					end else begin
						rem_c = r4[2:0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[KD+d] && vin[KD+d-1]) begin
				dv_dq_s[d]   <= dq_in;
				dv_rem_s[d]  <= rem_c;
				dv_quo_s[d]  <= quo_c;
				dv_sat_s[d]  <= sat_in;
				dv_seg_s[d]  <= seg_in;
				dv_zero_s[d] <= zero_in;
			end
		end
	end

	// Final stage: add the earlier segments' distance and saturate.
	assign dsum_c = dist_accel + dist_cruise;
	always_comb begin
		unique case (dv_seg_s[NDS-1])
			SEG_ACCEL:  base_c = '0;
			SEG_CRUISE: base_c = dist_accel;
			default:    base_c = dsum_c[VW] ? VMAX : dsum_c[VW-1:0];
		endcase
	end
	assign segd_c = dv_sat_s[NDS-1] ? VMAX : dv_quo_s[NDS-1];
	assign tot_c  = base_c + segd_c;

	always_ff @(posedge clk) begin
		if (rdy[NS] && vin[NS-1]) begin
			if (dv_zero_s[NDS-1]) begin
				dist_sf <= '0;
				seg_sf  <= SEG_ACCEL;
			end else begin
				dist_sf <= tot_c[VW] ? VMAX : tot_c[VW-1:0];
				seg_sf  <= dv_seg_s[NDS-1];
			end
		end
	end

	assign out_valid = v_q[NS];
	assign out_seg   = seg_sf;
	assign out_dist  = dist_sf;

endmodule

### rtl/feed_distance_profile.sv
// ----------------------------------------------------------------------------
// feed_distance_profile: distance along a path at a normalized trip time.
//
// Software writes the planned speeds, segment times and segment distances
// through the write port (cfg_we, cfg_index, cfg_data) while no sample is
// in flight. Each beat on the s_ channel carries one tau in Q1.16; values
// above one are taken as one. Each beat on the m_ channel returns the
// distance in Q16.16 (saturated) and the segment code in tuser.
// Throughput is one beat per cycle while the receiver is ready. The
// pipeline has three front stages, a local time division stage for the
// end test and one per quotient bit, one de Casteljau level per stage,
// and the scaling stages with a divide by six resolving eight bits per
// stage. Reset clears the configuration registers and the stage valid
// bits, which empties the pipeline. Every stage holds its beat while the
// next one is full and stalled, so a stalled receiver loses nothing;
// bubbles close up as the pipeline fills.
// ----------------------------------------------------------------------------
module feed_distance_profile #(
	parameter int TAU_FRAC_BITS = 16,
	parameter int VALUE_WIDTH   = 32,
	localparam int IN_TDATA_W   = ((TAU_FRAC_BITS + 8) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [fdp_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [VALUE_WIDTH-1:0]          cfg_data,
	// Input stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_TDATA_W-1:0]           s_tdata,   // norm_time
	// Output stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fdp_pkg::DIST_W-1:0]      m_tdata,   // distance
	output logic [1:0]                      m_tuser    // segment
);
	import fdp_pkg::*;

	localparam int EL_W = TAU_FRAC_BITS + VALUE_WIDTH + 2;

	logic [VALUE_WIDTH-1:0] cfg_q [0:NUM_REGS-1];

	logic                   fr_valid, fr_ready, fr_zero;
	seg_t                   fr_seg;
	logic [EL_W-1:0]        fr_num;
	logic                   td_valid, td_ready, td_zero;
	seg_t                   td_seg;
	logic [TAU_FRAC_BITS:0] td_t;
	logic                   bn_valid, bn_ready, bn_zero;
	seg_t                   bn_seg;
	logic [WEIGHT_W-1:0]    bn_wa, bn_wb;
	seg_t                   sc_seg;
	logic [VALUE_WIDTH-1:0] sc_dist;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	fdp_front #(
		.TAU_FRAC_BITS (TAU_FRAC_BITS),
		.VALUE_WIDTH   (VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.tau         (s_tdata[TAU_FRAC_BITS:0]),
		.time_accel  (cfg_q[REG_TIME_ACCEL]),
		.time_cruise (cfg_q[REG_TIME_CRUISE]),
		.time_decel  (cfg_q[REG_TIME_DECEL]),
		.out_valid   (fr_valid),
		.out_ready   (fr_ready),
		.out_seg     (fr_seg),
		.out_num     (fr_num),
		.out_zero    (fr_zero)
	);

	fdp_tdiv #(
		.TAU_FRAC_BITS (TAU_FRAC_BITS),
		.VALUE_WIDTH   (VALUE_WIDTH)
	) u_tdiv (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (fr_valid),
		.in_ready    (fr_ready),
		.in_seg      (fr_seg),
		.in_num      (fr_num),
		.in_zero     (fr_zero),
		.time_accel  (cfg_q[REG_TIME_ACCEL]),
		.time_cruise (cfg_q[REG_TIME_CRUISE]),
		.time_decel  (cfg_q[REG_TIME_DECEL]),
		.out_valid   (td_valid),
		.out_ready   (td_ready),
		.out_seg     (td_seg),
		.out_t       (td_t),
		.out_zero    (td_zero)
	);

	fdp_bern #(
		.TAU_FRAC_BITS (TAU_FRAC_BITS)
	) u_bern (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (td_valid),
		.in_ready  (td_ready),
		.in_seg    (td_seg),
		.in_t      (td_t),
		.in_zero   (td_zero),
		.out_valid (bn_valid),
		.out_ready (bn_ready),
		.out_seg   (bn_seg),
		.out_wa    (bn_wa),
		.out_wb    (bn_wb),
		.out_zero  (bn_zero)
	);

	fdp_scale #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (bn_valid),
		.in_ready     (bn_ready),
		.in_seg       (bn_seg),
		.in_wa        (bn_wa),
		.in_wb        (bn_wb),
		.in_zero      (bn_zero),
		.speed_start  (cfg_q[REG_SPEED_START]),
		.speed_cruise (cfg_q[REG_SPEED_CRUISE]),
		.speed_end    (cfg_q[REG_SPEED_END]),
		.time_accel   (cfg_q[REG_TIME_ACCEL]),
		.time_cruise  (cfg_q[REG_TIME_CRUISE]),
		.time_decel   (cfg_q[REG_TIME_DECEL]),
		.dist_accel   (cfg_q[REG_DIST_ACCEL]),
		.dist_cruise  (cfg_q[REG_DIST_CRUISE]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_seg      (sc_seg),
		.out_dist     (sc_dist)
	);

	// Result beat: distance is carried in the output field width.
	assign m_tdata = DIST_W'(sc_dist);
	assign m_tuser = sc_seg;

endmodule
